// ===== rtl/core/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ecf_pkg.sv =====
`timescale 1ns / 1ps

package ecf_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;

    localparam int VW  = 11;
    localparam int VIW = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int SW  = EW + 1;
    localparam int DW  = SW + 1;
    localparam int PW  = $clog2(MAX_EDGES + 1);
    localparam int CFG_W = 13;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SOLVE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_IMPOSSIBLE = 2'd1;
    localparam logic [1:0] STATUS_BAD        = 2'd2;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_EDGE_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [10:0] node_a;
        logic [10:0] node_b;
        logic [12:0] position;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] path_length;
        logic [10:0] vertex;
    } rsp_t;

    typedef struct packed {
        logic [SW-1:0] head;
        logic [SW-1:0] tail;
        logic [DW-1:0] deg;
        logic [SW-1:0] cur;
        logic [DW-1:0] seen;
        logic          visited;
    } vrec_t;

    function automatic vrec_t append_slot(vrec_t r, logic [SW-1:0] s);
        vrec_t n;
        n = r;
        if (r.deg == '0)
        begin
            n.head = s;
        end
        n.tail = s;
        n.deg  = r.deg + 1'b1;
        return n;
    endfunction

endpackage

// ===== rtl/core/euler_circuit_finder_core.sv =====
// channel   ports                      accepted when
// command   start, cmd, busy           start high and busy low at clk rise
// result    done, rsp                  the one cycle done is high
// config    cfg_we, cfg_index, cfg_data cfg_we high at clk rise
//
// after reset the vertex table is cleared with busy high.
// edge load steps through ld_aw, ld_b and ld_bw, path read through rd; a rejected item returns from idle.
// solve clears the used flags and vertex cursors, runs a dfs over vertices and slots,
// then walks the circuit: it pops vertices, takes edges and skips used slots.
// the vertex and adjacency memories each have a single read port.
// results are a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module euler_circuit_finder_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  ecf_pkg::cmd_t             cmd,
    output logic                      busy,
    output logic                      done,
    output ecf_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [ecf_pkg::CFG_W-1:0] cfg_data
);

    import ecf_pkg::*;

    localparam int VREC_W = $bits(vrec_t);
    localparam int ENDS_W = 2 * VW;
    localparam logic [VW-1:0] MAX_NODE_NUM = VW'(MAX_NODES);
    localparam logic [PW-1:0] EDGE_LIMIT   = PW'(MAX_EDGES);
    localparam logic [PW-1:0] LAST_VTX     = PW'(MAX_NODES - 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LD_AW, ST_LD_B, ST_LD_BW, ST_RD,
        ST_CLR_E, ST_CLR_V, ST_CLR_VW,
        ST_D_INIT, ST_D_INITW, ST_D_POP, ST_D_POPW, ST_D_U, ST_D_SLOT, ST_D_SLOTW,
        ST_D_W, ST_D_END,
        ST_W_TOP, ST_W_TOPW, ST_W_U, ST_W_CHK, ST_W_CHKW
    } state_t;

    state_t          state_reg;
    logic [10:0]     node_count_reg;
    logic [12:0]     edge_count_reg;
    logic [PW-1:0]   edges_loaded_reg;
    logic [PW-1:0]   circuit_length_reg;
    logic [VW-1:0]   max_end_reg;
    logic [VW-1:0]   odd_count_reg;
    logic [VW-1:0]   nz_count_reg;
    logic [VW-1:0]   nz_seen_reg;
    logic [PW-1:0]   idx_reg;
    cmd_t            cmd_reg;
    logic [VIW-1:0]  u_reg;
    logic [VIW-1:0]  w_reg;
    logic [SW-1:0]   slot_reg;
    logic [DW-1:0]   left_reg;
    logic [PW-1:0]   sp_reg;
    logic [PW-1:0]   len_reg;
    vrec_t           rec_reg;
    logic            done_reg;
    rsp_t            rsp_reg;

    logic              vtx_we;
    logic [VIW-1:0]    vtx_waddr, vtx_raddr;
    logic [VREC_W-1:0] vtx_wdata, vtx_rdata;
    logic              ends_we;
    logic [EW-1:0]     ends_waddr, ends_raddr;
    logic [ENDS_W-1:0] ends_wdata, ends_rdata;
    logic              adj_we;
    logic [SW-1:0]     adj_waddr, adj_raddr, adj_wdata, adj_rdata;
    logic              used_we;
    logic [EW-1:0]     used_waddr, used_raddr;
    logic              used_wdata, used_rdata;
    logic              stk_we;
    logic [PW-1:0]     stk_waddr, stk_raddr;
    logic [VIW-1:0]    stk_wdata, stk_rdata;
    logic              cir_we;
    logic [PW-1:0]     cir_waddr, cir_raddr;
    logic [VW-1:0]     cir_wdata, cir_rdata;

    vrec_t          vtx_rd;
    vrec_t          rec_upd;
    vrec_t          rec_tmp;
    logic           ld_ok;
    logic           nb_sel;
    logic [VW-1:0]  nb;
    logic [VIW-1:0] nb_idx;
    logic [EW-1:0]  e_idx;
    logic [VIW-1:0] a_idx, b_idx;
    logic [VW-1:0]  big_end;
    logic           plen_ok;

    ecf_ram #(.WIDTH(VREC_W), .DEPTH(MAX_NODES)) u_vtx (
        .clk(clk), .we(vtx_we), .waddr(vtx_waddr), .wdata(vtx_wdata),
        .raddr(vtx_raddr), .rdata(vtx_rdata)
    );
    ecf_ram #(.WIDTH(ENDS_W), .DEPTH(MAX_EDGES)) u_ends (
        .clk(clk), .we(ends_we), .waddr(ends_waddr), .wdata(ends_wdata),
        .raddr(ends_raddr), .rdata(ends_rdata)
    );
    ecf_ram #(.WIDTH(SW), .DEPTH(2 * MAX_EDGES)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );
    ecf_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_used (
        .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
        .raddr(used_raddr), .rdata(used_rdata)
    );
    ecf_ram #(.WIDTH(VIW), .DEPTH(MAX_EDGES + 1)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );
    ecf_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES + 1)) u_cir (
        .clk(clk), .we(cir_we), .waddr(cir_waddr), .wdata(cir_wdata),
        .raddr(cir_raddr), .rdata(cir_rdata)
    );

    assign vtx_rd  = vrec_t'(vtx_rdata);
    assign e_idx   = edges_loaded_reg[EW-1:0];
    assign a_idx   = VIW'(cmd_reg.node_a - 11'd1);
    assign b_idx   = VIW'(cmd_reg.node_b - 11'd1);
    assign big_end = (cmd_reg.node_a > cmd_reg.node_b) ? cmd_reg.node_a : cmd_reg.node_b;
    assign nb_sel  = (state_reg == ST_W_CHKW) ? rec_reg.cur[0] : slot_reg[0];
    assign nb      = nb_sel ? ends_rdata[ENDS_W-1:VW] : ends_rdata[VW-1:0];
    assign nb_idx  = VIW'(nb - VW'(1));

    assign ld_ok = (edges_loaded_reg < PW'(edge_count_reg)) && (edges_loaded_reg < EDGE_LIMIT)
                && (cmd.node_a != '0) && (cmd.node_b != '0)
                && (cmd.node_a <= node_count_reg) && (cmd.node_b <= node_count_reg)
                && (cmd.node_a <= MAX_NODE_NUM) && (cmd.node_b <= MAX_NODE_NUM);

    always_comb
    begin
        rec_upd      = rec_reg;
        rec_upd.cur  = adj_rdata;
        rec_upd.seen = rec_reg.seen + 1'b1;
    end

    always_comb
    begin
        vtx_we = 1'b0; vtx_waddr = '0; vtx_wdata = '0; vtx_raddr = '0;
        ends_we = 1'b0; ends_waddr = '0; ends_wdata = '0; ends_raddr = '0;
        adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0; adj_raddr = '0;
        used_we = 1'b0; used_waddr = '0; used_wdata = 1'b0; used_raddr = '0;
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
        cir_we = 1'b0; cir_waddr = '0; cir_wdata = '0; cir_raddr = '0;
        rec_tmp = vtx_rd;
        unique case (state_reg)
            ST_CLEAR:
            begin
                vtx_we    = 1'b1;
                vtx_waddr = idx_reg[VIW-1:0];
            end
            ST_IDLE:
            begin
                ends_we    = start && (cmd.mode == MODE_LOAD) && ld_ok;
                ends_waddr = e_idx;
                ends_wdata = {cmd.node_a, cmd.node_b};
                vtx_raddr  = VIW'(cmd.node_a - 11'd1);
                cir_raddr  = cmd.position;
            end
            ST_LD_AW:
            begin
                vtx_we    = 1'b1;
                vtx_waddr = a_idx;
                vtx_wdata = append_slot(vtx_rd, {e_idx, 1'b0});
                adj_we    = (vtx_rd.deg != '0);
                adj_waddr = vtx_rd.tail;
                adj_wdata = {e_idx, 1'b0};
            end
            ST_LD_B:
            begin
                vtx_raddr = b_idx;
            end
            ST_LD_BW:
            begin
                vtx_we    = 1'b1;
                vtx_waddr = b_idx;
                vtx_wdata = append_slot(vtx_rd, {e_idx, 1'b1});
                adj_we    = (vtx_rd.deg != '0);
                adj_waddr = vtx_rd.tail;
                adj_wdata = {e_idx, 1'b1};
            end
            ST_CLR_E:
            begin
                used_we    = (idx_reg != edges_loaded_reg);
                used_waddr = idx_reg[EW-1:0];
            end
            ST_CLR_V:
            begin
                vtx_raddr = idx_reg[VIW-1:0];
            end
            ST_CLR_VW:
            begin
                rec_tmp.cur     = vtx_rd.head;
                rec_tmp.seen    = '0;
                rec_tmp.visited = 1'b0;
                vtx_we    = 1'b1;
                vtx_waddr = idx_reg[VIW-1:0];
                vtx_wdata = rec_tmp;
            end
            ST_D_INIT:
            begin
                vtx_raddr = '0;
            end
            ST_D_INITW:
            begin
                rec_tmp.visited = 1'b1;
                vtx_we    = 1'b1;
                vtx_waddr = '0;
                vtx_wdata = rec_tmp;
                stk_we    = 1'b1;
            end
            ST_D_POP:
            begin
                stk_raddr = sp_reg - 1'b1;
            end
            ST_D_POPW:
            begin
                vtx_raddr = stk_rdata;
            end
            ST_D_SLOT:
            begin
                ends_raddr = slot_reg[SW-1:1];
                adj_raddr  = slot_reg;
            end
            ST_D_SLOTW:
            begin
                vtx_raddr = nb_idx;
            end
            ST_D_W:
            begin
                rec_tmp.visited = 1'b1;
                vtx_we    = !vtx_rd.visited;
                vtx_waddr = w_reg;
                vtx_wdata = rec_tmp;
                stk_we    = !vtx_rd.visited;
                stk_waddr = sp_reg;
                stk_wdata = w_reg;
            end
            ST_D_END:
            begin
                stk_we = (nz_seen_reg == nz_count_reg);
            end
            ST_W_TOP:
            begin
                stk_raddr = sp_reg - 1'b1;
            end
            ST_W_TOPW:
            begin
                vtx_raddr = stk_rdata;
            end
            ST_W_CHK:
            begin
                if (rec_reg.seen == rec_reg.deg)
                begin
                    vtx_we    = 1'b1;
                    vtx_waddr = u_reg;
                    vtx_wdata = rec_reg;
                    cir_we    = (len_reg <= EDGE_LIMIT);
                    cir_waddr = len_reg;
                    cir_wdata = VW'(u_reg) + VW'(1);
                end
                else
                begin
                    used_raddr = rec_reg.cur[SW-1:1];
                    ends_raddr = rec_reg.cur[SW-1:1];
                    adj_raddr  = rec_reg.cur;
                end
            end
            ST_W_CHKW:
            begin
                if (!used_rdata)
                begin
                    vtx_we     = 1'b1;
                    vtx_waddr  = u_reg;
                    vtx_wdata  = rec_upd;
                    used_we    = (sp_reg <= EDGE_LIMIT);
                    used_waddr = rec_reg.cur[SW-1:1];
                    used_wdata = 1'b1;
                    stk_we     = (sp_reg <= EDGE_LIMIT);
                    stk_waddr  = sp_reg;
                    stk_wdata  = nb_idx;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            node_count_reg     <= 11'd1;
            edge_count_reg     <= '0;
            edges_loaded_reg   <= '0;
            circuit_length_reg <= '0;
            max_end_reg        <= '0;
            odd_count_reg      <= '0;
            nz_count_reg       <= '0;
            nz_seen_reg        <= '0;
            idx_reg            <= '0;
            sp_reg             <= '0;
            len_reg            <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NODE_COUNT: node_count_reg <= cfg_data[10:0];
                    REG_EDGE_COUNT: edge_count_reg <= cfg_data[12:0];
                    default:
                    begin
                    end
                endcase
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST_VTX)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= cmd;
                        unique case (cmd.mode)
                            MODE_LOAD:
                            begin
                                if (ld_ok)
                                begin
                                    state_reg <= ST_LD_AW;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                    rsp_reg  <= '{STATUS_BAD, '0, '0};
                                end
                            end
                            MODE_SOLVE:
                            begin
                                circuit_length_reg <= '0;
                                if (edges_loaded_reg != edge_count_reg || node_count_reg == '0
                                    || node_count_reg > MAX_NODE_NUM
                                    || max_end_reg > node_count_reg)
                                begin
                                    done_reg <= 1'b1;
                                    rsp_reg  <= '{STATUS_BAD, '0, '0};
                                end
                                else if (odd_count_reg != '0)
                                begin
                                    done_reg <= 1'b1;
                                    rsp_reg  <= '{STATUS_IMPOSSIBLE, '0, '0};
                                end
                                else
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= ST_CLR_E;
                                end
                            end
                            MODE_READ:
                            begin
                                if (cmd.position < circuit_length_reg)
                                begin
                                    state_reg <= ST_RD;
                                end
                                else
                                begin
                                    done_reg <= 1'b1;
                                    rsp_reg  <= '{STATUS_BAD, '0, '0};
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                                rsp_reg  <= '{STATUS_BAD, '0, '0};
                            end
                        endcase
                    end
                end
                ST_LD_AW, ST_LD_BW:
                begin
                    if (vtx_rd.deg == '0)
                    begin
                        nz_count_reg <= nz_count_reg + 1'b1;
                    end
                    if (vtx_rd.deg[0])
                    begin
                        odd_count_reg <= odd_count_reg - 1'b1;
                    end
                    else
                    begin
                        odd_count_reg <= odd_count_reg + 1'b1;
                    end
                    if (state_reg == ST_LD_AW)
                    begin
                        state_reg <= ST_LD_B;
                    end
                    else
                    begin
                        edges_loaded_reg   <= edges_loaded_reg + 1'b1;
                        circuit_length_reg <= '0;
                        if (big_end > max_end_reg)
                        begin
                            max_end_reg <= big_end;
                        end
                        done_reg  <= 1'b1;
                        rsp_reg   <= '{STATUS_OK, '0, '0};
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LD_B:
                begin
                    state_reg <= ST_LD_BW;
                end
                ST_RD:
                begin
                    done_reg  <= 1'b1;
                    rsp_reg   <= '{STATUS_OK, '0, cir_rdata};
                    state_reg <= ST_IDLE;
                end
                ST_CLR_E:
                begin
                    if (idx_reg == edges_loaded_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_CLR_V;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_CLR_V:
                begin
                    if (idx_reg == PW'(node_count_reg))
                    begin
                        state_reg <= ST_D_INIT;
                    end
                    else
                    begin
                        state_reg <= ST_CLR_VW;
                    end
                end
                ST_CLR_VW:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_CLR_V;
                end
                ST_D_INIT:
                begin
                    state_reg <= ST_D_INITW;
                end
                ST_D_INITW:
                begin
                    sp_reg      <= PW'(1);
                    nz_seen_reg <= '0;
                    state_reg   <= ST_D_POP;
                end
                ST_D_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= ST_D_END;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg - 1'b1;
                        state_reg <= ST_D_POPW;
                    end
                end
                ST_D_POPW:
                begin
                    state_reg <= ST_D_U;
                end
                ST_D_U:
                begin
                    slot_reg <= vtx_rd.head;
                    left_reg <= vtx_rd.deg;
                    if (vtx_rd.deg != '0)
                    begin
                        nz_seen_reg <= nz_seen_reg + 1'b1;
                        state_reg   <= ST_D_SLOT;
                    end
                    else
                    begin
                        state_reg <= ST_D_POP;
                    end
                end
                ST_D_SLOT:
                begin
                    state_reg <= ST_D_SLOTW;
                end
                ST_D_SLOTW:
                begin
                    w_reg     <= nb_idx;
                    slot_reg  <= adj_rdata;
                    left_reg  <= left_reg - 1'b1;
                    state_reg <= ST_D_W;
                end
                ST_D_W:
                begin
                    if (!vtx_rd.visited)
                    begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                    state_reg <= (left_reg == '0) ? ST_D_POP : ST_D_SLOT;
                end
                ST_D_END:
                begin
                    if (nz_seen_reg != nz_count_reg)
                    begin
                        done_reg  <= 1'b1;
                        rsp_reg   <= '{STATUS_IMPOSSIBLE, '0, '0};
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        sp_reg    <= PW'(1);
                        len_reg   <= '0;
                        state_reg <= ST_W_TOP;
                    end
                end
                ST_W_TOP:
                begin
                    if (sp_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                        if (len_reg == edges_loaded_reg + 1'b1)
                        begin
                            circuit_length_reg <= len_reg;
                            rsp_reg <= '{STATUS_OK, len_reg, '0};
                        end
                        else
                        begin
                            rsp_reg <= '{STATUS_IMPOSSIBLE, '0, '0};
                        end
                    end
                    else
                    begin
                        state_reg <= ST_W_TOPW;
                    end
                end
                ST_W_TOPW:
                begin
                    u_reg     <= stk_rdata;
                    state_reg <= ST_W_U;
                end
                ST_W_U:
                begin
                    rec_reg   <= vtx_rd;
                    state_reg <= ST_W_CHK;
                end
                ST_W_CHK:
                begin
                    if (rec_reg.seen == rec_reg.deg)
                    begin
                        if (len_reg <= EDGE_LIMIT)
                        begin
                            len_reg <= len_reg + 1'b1;
                        end
                        sp_reg    <= sp_reg - 1'b1;
                        state_reg <= ST_W_TOP;
                    end
                    else
                    begin
                        state_reg <= ST_W_CHKW;
                    end
                end
                ST_W_CHKW:
                begin
                    rec_reg <= rec_upd;
                    if (used_rdata)
                    begin
                        state_reg <= ST_W_CHK;
                    end
                    else
                    begin
                        if (sp_reg <= EDGE_LIMIT)
                        begin
                            sp_reg <= sp_reg + 1'b1;
                        end
                        state_reg <= ST_W_TOP;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign plen_ok = (rsp_reg.status == STATUS_OK) && (rsp_reg.path_length == circuit_length_reg);

`include "assert_macros.svh"

    `ASSERT_IMPL(a_done_idle, done_reg, state_reg == ST_IDLE, "result strobe outside idle")
    `ASSERT_NEXT(a_accept_acts, start && state_reg == ST_IDLE, busy || done_reg, "item dropped")
    `ASSERT_IMPL(a_sp_bound, state_reg != ST_CLEAR, sp_reg <= EDGE_LIMIT + 1'b1, "stack overrun")
    `ASSERT_IMPL(a_plen_match, done_reg && rsp_reg.path_length != '0, plen_ok, "bad length")

endmodule

// ===== rtl/core/ecf_ram.sv =====
`timescale 1ns / 1ps

module ecf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
